// File: hdl/fbpa_pkg.sv
// fbpa_pkg: shared types and constants for the fixed block pool allocator.
// Used by fbpa_ctrl, fbpa_dp and fixed_block_pool_allocator; depends on nothing.
package fbpa_pkg;

    localparam int POOL_BLOCKS = 64;
    localparam int IDX_W       = $clog2(POOL_BLOCKS);
    localparam int CNT_W       = $clog2(POOL_BLOCKS + 1);
    localparam int STAT_W      = 2;

    // request opcodes
    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NONE_USED = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // controller -> datapath commands
    typedef struct packed {
        logic capture;  // latch request fields, start link read at head
        logic exec;     // apply the request and register the result
    } t_cmd;

endpackage

// File: hdl/fbpa_ctrl.sv
// fbpa_ctrl: request sequencer for the block pool allocator.
// Depends on fbpa_pkg; drives commands into fbpa_dp.
module fbpa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    output fbpa_pkg::t_cmd o_cmd
);
    import fbpa_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        busy  = 1'b0;
        unique case (r_state)
            S_IDLE: o_cmd.capture = start;
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                busy       = 1'b1;
            end
            default: busy = 1'b0;
        endcase
    end

endmodule

// File: hdl/fbpa_dp.sv
// fbpa_dp: free-list datapath: link memory, head pointer, counters, result regs.
// Depends on fbpa_pkg; sequenced by fbpa_ctrl.
module fbpa_dp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  fbpa_pkg::t_cmd            i_cmd,
    input  logic                      i_op,
    input  logic [fbpa_pkg::IDX_W-1:0] i_return_index,
    output logic                      o_done,
    output logic [fbpa_pkg::IDX_W-1:0] o_granted_index,
    output logic [fbpa_pkg::STAT_W-1:0] o_status,
    output logic [fbpa_pkg::CNT_W-1:0] o_free_blocks
);
    import fbpa_pkg::*;

    logic [IDX_W-1:0] r_link_mem [POOL_BLOCKS];
    logic [POOL_BLOCKS-1:0] r_link_vld;   // unwritten entry reads as index + 1

    logic [IDX_W-1:0] r_head;
    logic [CNT_W-1:0] r_free_cnt;
    logic [CNT_W-1:0] r_used_cnt;

    logic             r_op;
    logic [IDX_W-1:0] r_ret;
    logic [IDX_W-1:0] r_rd_data;
    logic             r_rd_vld;
    logic [IDX_W-1:0] r_rd_dflt;

    logic             r_done;
    logic [IDX_W-1:0] r_granted;
    t_status          r_status;
    logic [CNT_W-1:0] r_free_out;

    logic [IDX_W-1:0] n_head_dflt;
    logic [IDX_W-1:0] link_next;
    logic             do_get;
    logic             do_put;

    // reset link of the head entry: head + 1, wrapping at the pool end
    always_comb begin
        if (r_head == IDX_W'(POOL_BLOCKS - 1)) begin
            n_head_dflt = '0;
        end else begin
            n_head_dflt = r_head + IDX_W'(1);
        end
    end

    assign link_next = r_rd_vld ? r_rd_data : r_rd_dflt;
    assign do_get    = i_cmd.exec && (r_op == OP_GET) && (r_free_cnt != '0);
    assign do_put    = i_cmd.exec && (r_op == OP_PUT) && (r_used_cnt != '0);

    // link memory: read at head on capture, written on put
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_rd_data <= r_link_mem[r_head];
        end
        if (do_put) begin
            r_link_mem[r_ret] <= r_head;
        end
    end

    // request capture (payload)
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op      <= i_op;
            r_ret     <= i_return_index;
            r_rd_dflt <= n_head_dflt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_vld <= '0;
            r_rd_vld   <= 1'b0;
            r_head     <= '0;
            r_free_cnt <= CNT_W'(POOL_BLOCKS);
            r_used_cnt <= '0;
            r_done     <= 1'b0;
        end else begin
            r_done <= i_cmd.exec;
            if (i_cmd.capture) begin
                r_rd_vld <= r_link_vld[r_head];
            end
            if (do_get) begin
                r_head     <= link_next;
                r_free_cnt <= r_free_cnt - CNT_W'(1);
                r_used_cnt <= r_used_cnt + CNT_W'(1);
            end else if (do_put) begin
                r_link_vld[r_ret] <= 1'b1;
                r_head            <= r_ret;
                r_free_cnt        <= r_free_cnt + CNT_W'(1);
                r_used_cnt        <= r_used_cnt - CNT_W'(1);
            end
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_granted  <= do_get ? r_head : '0;
            r_free_out <= r_free_cnt;
            r_status   <= ST_OK;
            if (do_get) begin
                r_free_out <= r_free_cnt - CNT_W'(1);
            end else if (do_put) begin
                r_free_out <= r_free_cnt + CNT_W'(1);
            end else if (r_op == OP_GET) begin
                r_status <= ST_EMPTY;
            end else begin
                r_status <= ST_NONE_USED;
            end
        end
    end

    assign o_done          = r_done;
    assign o_granted_index = r_granted;
    assign o_status        = r_status;
    assign o_free_blocks   = r_free_out;

endmodule

// File: hdl/fixed_block_pool_allocator.sv
// fixed_block_pool_allocator: top level of the LIFO free-list block allocator.
// Depends on fbpa_pkg, fbpa_ctrl and fbpa_dp.
//
//  channel   handshake                 fields
//  --------  ------------------------  -----------------------------------------
//  request   start (in) / busy (out)   i_op, i_return_index
//  result    o_done strobe, 1 cycle    o_granted_index, o_status, o_free_blocks
//
// A request runs through a capture cycle, which starts the registered read of
// the link at the head, and an execute cycle, which pops or pushes and loads
// the result. busy is high only in the execute cycle, so a new request is
// taken in the cycle o_done is shown and never before the last one has executed;
// the registered read port of the link memory sets this pace.
// Synchronous active-low reset: all blocks free, head 0, list in index order.
// Link entries not yet written read as index + 1 through per-entry valid bits,
// so no clearing pass is needed. The receiver cannot stall results.
module fixed_block_pool_allocator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_op,
    input  logic [fbpa_pkg::IDX_W-1:0]  i_return_index,
    output logic                        o_done,
    output logic [fbpa_pkg::IDX_W-1:0]  o_granted_index,
    output logic [fbpa_pkg::STAT_W-1:0] o_status,
    output logic [fbpa_pkg::CNT_W-1:0]  o_free_blocks
);
    import fbpa_pkg::*;

    // command bundle from the sequencer into the datapath
    t_cmd cmd;

    fbpa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    // link memory, head pointer, free/used counters and result registers
    fbpa_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_op            (i_op),
        .i_return_index  (i_return_index),
        .o_done          (o_done),
        .o_granted_index (o_granted_index),
        .o_status        (o_status),
        .o_free_blocks   (o_free_blocks)
    );

endmodule

// File: verif/fixed_block_pool_allocator_tb.sv
// fixed_block_pool_allocator_tb: self-checking testbench for the LIFO block pool allocator.
// Drives get/put requests over the start/busy port and checks each o_done result
// against a free-list model kept here. Depends on fbpa_pkg and fixed_block_pool_allocator.
module fixed_block_pool_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fbpa_pkg::*;

    // one result as the block reports it
    typedef struct packed {
        logic [IDX_W-1:0] granted;
        t_status          status;
        logic [CNT_W-1:0] free_blocks;
    } alloc_result_t;

    // directed stimulus row; reps > 1 repeats the request with the index
    // stepping by one each time (wrapping in 6 bits)
    typedef struct {
        logic             op;
        logic [IDX_W-1:0] idx;
        int               reps;
        bit               typed;      // use the hand-written result below
        logic [IDX_W-1:0] granted;
        t_status          status;
        logic [CNT_W-1:0] free_blocks;
    } dir_row_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_op;
    logic [IDX_W-1:0]   i_return_index;
    logic               o_done;
    logic [IDX_W-1:0]   o_granted_index;
    logic [STAT_W-1:0]  o_status;
    logic [CNT_W-1:0]   o_free_blocks;

    // free-list model state
    logic [IDX_W-1:0]   link_mem [POOL_BLOCKS];
    logic [IDX_W-1:0]   head_blk;
    int unsigned        free_cnt;
    int unsigned        used_cnt;

    alloc_result_t      expected_results [$];
    logic [IDX_W-1:0]   blocks_held [$];     // blocks handed out and not yet returned
    int                 mismatch_count = 0;

    // Walk from reset: empty-handed put, a few pops, a push of the top index,
    // then drain the pool to the last block, hit the empty case, push onto an
    // empty list, refill it completely and hit the nothing-in-use case.
    dir_row_t dir_table [15] = '{
        '{OP_PUT,  5,  1, 1,  0, ST_NONE_USED, 64},  // nothing handed out yet
        '{OP_GET,  0,  1, 1,  0, ST_OK,        63},  // head is block 0 after reset
        '{OP_GET,  0,  1, 1,  1, ST_OK,        62},
        '{OP_PUT, 63,  1, 1,  0, ST_OK,        63},  // top index, block was free already
        '{OP_GET,  0,  1, 1, 63, ST_OK,        62},  // LIFO: the block just pushed
        '{OP_GET,  0, 61, 0,  0, ST_OK,         0},  // drain down to one free block
        '{OP_GET,  0,  1, 0,  0, ST_OK,         0},  // take the last free block
        '{OP_GET, 63,  1, 1,  0, ST_EMPTY,      0},  // pool exhausted, index ignored
        '{OP_PUT,  0,  1, 1,  0, ST_OK,         1},  // push onto an empty list
        '{OP_GET,  0,  1, 1,  0, ST_OK,         0},
        '{OP_GET,  0,  1, 1,  0, ST_EMPTY,      0},
        '{OP_PUT, 10, 64, 0,  0, ST_OK,         0},  // return every block, wrapping index
        '{OP_PUT,  0,  1, 1,  0, ST_NONE_USED, 64},  // pool full again
        '{OP_GET,  0,  3, 0,  0, ST_OK,         0},
        '{OP_PUT, 42,  1, 0,  0, ST_OK,         0}
    };

    fixed_block_pool_allocator i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_op            (i_op),
        .i_return_index  (i_return_index),
        .o_done          (o_done),
        .o_granted_index (o_granted_index),
        .o_status        (o_status),
        .o_free_blocks   (o_free_blocks)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Pop the head on get, push the index on put; counts guard both.
    function automatic alloc_result_t apply_request(logic op, logic [IDX_W-1:0] idx);
        alloc_result_t res;
        res.granted = '0;
        res.status  = ST_OK;
        if (op == OP_GET) begin
            if (free_cnt == 0) begin
                res.status = ST_EMPTY;
            end else begin
                res.granted = head_blk;
                head_blk    = link_mem[head_blk];
                free_cnt--;
                used_cnt++;
            end
        end else begin
            if (used_cnt == 0) begin
                res.status = ST_NONE_USED;
            end else begin
                link_mem[idx] = head_blk;
                head_blk      = idx;
                free_cnt++;
                used_cnt--;
            end
        end
        res.free_blocks = CNT_W'(free_cnt);
        return res;
    endfunction

    // Called at a clock edge. Idles for gap cycles, then holds start until the
    // request is taken (start high, busy low at an edge) and returns the
    // predicted result. Keeps the held-block list in step for the random part.
    task automatic issue_request(input logic op, input logic [IDX_W-1:0] idx,
                                 input int gap, output alloc_result_t res);
        int hits [$];
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_op           <= op;
        i_return_index <= idx;
        do @(posedge i_clk); while (busy);
        res = apply_request(op, idx);
        if (op == OP_GET && res.status == ST_OK) begin
            blocks_held.push_back(res.granted);
        end else if (op == OP_PUT && res.status == ST_OK) begin
            hits = blocks_held.find_first_index(b) with (b == idx);
            if (hits.size() != 0) blocks_held.delete(hits[0]);
        end
    endtask

    // Sender backs off until every outstanding result has come back.
    task automatic wait_all_results();
        start <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    task automatic note_mismatch(input string what);
        if (mismatch_count < 10) $display("%t: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Result checker: o_done marks a one-cycle result, taken at the edge that
    // ends it; compare against the oldest pending prediction.
    always @(posedge i_clk) begin
        alloc_result_t want;
        if (i_rst_n && o_done) begin
            if (expected_results.size() == 0) begin
                note_mismatch($sformatf("unexpected result: idx %0d status %0d free %0d",
                                        o_granted_index, o_status, o_free_blocks));
            end else begin
                want = expected_results.pop_front();
                if (o_granted_index !== want.granted || o_status !== want.status ||
                    o_free_blocks !== want.free_blocks) begin
                    note_mismatch($sformatf(
                        {"mismatch: idx exp %0d got %0d, status exp %0d got %0d, ",
                         "free exp %0d got %0d"},
                        want.granted, o_granted_index, want.status, o_status,
                        want.free_blocks, o_free_blocks));
                end
            end
        end
    end

    initial begin
        alloc_result_t    res;
        logic [IDX_W-1:0] idx;
        logic             op;
        int               get_pct;
        bit               no_idle;

        start          = 1'b0;
        i_op           = OP_GET;
        i_return_index = '0;
        i_rst_n        = 1'b0;

        // model reset: list runs 0, 1, 2, ... with head 0, everything free
        for (int i = 0; i < POOL_BLOCKS; i++) link_mem[i] = IDX_W'(i + 1);
        head_blk = '0;
        free_cnt = POOL_BLOCKS;
        used_cnt = 0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed walk through the table
        foreach (dir_table[r]) begin
            for (int k = 0; k < dir_table[r].reps; k++) begin
                idx = dir_table[r].idx + k[IDX_W-1:0];
                issue_request(dir_table[r].op, idx,
                              $urandom_range(0, 1) ? 0 : $urandom_range(0, 17), res);
                if (dir_table[r].typed) begin
                    res.granted     = dir_table[r].granted;
                    res.status      = dir_table[r].status;
                    res.free_blocks = dir_table[r].free_blocks;
                end
                expected_results.push_back(res);
            end
        end

        wait_all_results();

        // Random part in bursts: each burst picks a get/put mix so the pool
        // swings between full and empty, and whether the sender idles at all.
        // Puts mostly return a block actually held, sometimes any index.
        get_pct = 50;
        no_idle = 1'b0;
        for (int n = 0; n < 510; n++) begin
            if (n % 60 == 0) begin
                get_pct = $urandom_range(5, 95);
                no_idle = ($urandom_range(0, 3) == 0);
            end
            if (n % 150 == 149) wait_all_results();
            op = ($urandom_range(1, 100) <= get_pct) ? OP_GET : OP_PUT;
            if (op == OP_PUT && blocks_held.size() != 0 && $urandom_range(1, 100) <= 85)
                idx = blocks_held[$urandom_range(0, blocks_held.size() - 1)];
            else
                idx = IDX_W'($urandom_range(0, POOL_BLOCKS - 1));
            issue_request(op, idx, no_idle ? 0 : $urandom_range(0, 17), res);
            expected_results.push_back(res);
        end

        wait_all_results();
        repeat (6) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // hang guard, far above the slowest legal run
    initial begin
        #2ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// File: filelist.f
hdl/fbpa_pkg.sv
hdl/fbpa_ctrl.sv
hdl/fbpa_dp.sv
hdl/fixed_block_pool_allocator.sv
verif/fixed_block_pool_allocator_tb.sv
